[src/tcps_pkg.sv]
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types and constants for the time code pulse sampler: sampler phase
// codes, pulse codes, register indexes and the pattern classification table.
// ----------------------------------------------------------------------------
package tcps_pkg;

    // Configuration port geometry.
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 4'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FIRST_DELAY_RST = 20'd350;
    localparam logic [CFG_W-1:0] INTERVAL_RST    = 20'd100;

    // Second counter.
    localparam int               SEC_W    = 6;
    localparam logic [SEC_W-1:0] SEC_LAST = 6'd59;

    // Operation codes of an input item.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PULSE = 1'b1;

    // Sampler phase codes.
    localparam int                 PHASE_W     = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_READ0    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_READ1    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_READ2    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE     = 3'd6;

    // Pulse codes.
    localparam logic [1:0] CODE_MARKER = 2'd0;
    localparam logic [1:0] CODE_HIGH   = 2'd1;
    localparam logic [1:0] CODE_LOW    = 2'd2;
    localparam logic [1:0] CODE_UNDEF  = 2'd3;

    // Marker run counter.
    localparam logic [1:0] RUN_MAX  = 2'd3;
    localparam logic [1:0] RUN_SYNC = 2'd2;

    // One classified second as it leaves the sampler.
    typedef struct packed {
        logic             valid;
        logic [1:0]       pulse_code;
        logic [SEC_W-1:0] second_index;
        logic             frame_synced;
        logic             minute_end;
    } t_result;

    // Sorts a 4-bit sample pattern (first sample in the MSB) into a pulse code.
    function automatic logic [1:0] classify(input logic [3:0] pattern);
        logic [1:0] code;
        case (pattern)
            4'h0:    code = CODE_MARKER;
            4'h4:    code = CODE_HIGH;
            4'h7:    code = CODE_LOW;
            4'h8:    code = CODE_HIGH;
            4'h9:    code = CODE_LOW;
            4'hA:    code = CODE_HIGH;
            4'hB:    code = CODE_LOW;
            4'hC:    code = CODE_HIGH;
            4'hD:    code = CODE_LOW;
            4'hE:    code = CODE_HIGH;
            4'hF:    code = CODE_LOW;
            default: code = CODE_UNDEF;
        endcase
        return code;
    endfunction

endpackage

[src/time_code_pulse_sampler_top.sv]
// ----------------------------------------------------------------------------
// time_code_pulse_sampler_top
// Samples the demodulated carrier of a time code signal four times per second
// and sorts each second into marker, high, low or undefined.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | sink      | i_in_valid / o_in_ready    | i_operation, i_carrier_level
//   out     | source    | o_out_valid / i_out_ready  | o_pulse_code, o_second_index,
//           |           |                            | o_frame_synced, o_minute_end
//   cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item is accepted per cycle unless the output side stalls. An item
// waits in the input register, then updates the sampler state; its
// result, if any, enters the output register with that state update.
// A synchronous active-low reset restores the register defaults and idles
// the sampler. When the output register holds an untaken result, the input
// register holds its item and input ready drops once that register is full.
// ----------------------------------------------------------------------------
module time_code_pulse_sampler_top #(
    parameter int TIMER_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic                          i_carrier_level,
    // Result items.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_pulse_code,
    output logic [tcps_pkg::SEC_W-1:0]    o_second_index,
    output logic                          o_frame_synced,
    output logic                          o_minute_end,
    // Configuration writes.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcps_pkg::CFG_W-1:0]    i_cfg_data
);
    import tcps_pkg::*;

    logic [CFG_W-1:0] r_delay;
    logic [CFG_W-1:0] r_interval;

    logic             r_in_valid;
    logic             r_in_op;
    logic             r_in_level;

    logic             r_out_valid;
    logic [1:0]       r_code;
    logic [SEC_W-1:0] r_second;
    logic             r_synced;
    logic             r_min_end;

    logic             w_advance;
    logic             w_step;
    t_result          w_result;

    // Configuration registers; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= FIRST_DELAY_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_FIRST_DELAY) begin
                r_delay <= i_cfg_data;
            end else if (i_cfg_index == REG_INTERVAL) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // The pipeline moves when the output register is free or being emptied.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = w_advance && r_in_valid;
    assign o_in_ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_op    <= i_operation;
            r_in_level <= i_carrier_level;
        end
    end

    // Sampler state and classification.
    tcps_sampler #(
        .TIMER_BITS (TIMER_BITS)
    ) u_sampler (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_operation     (r_in_op),
        .i_carrier_level (r_in_level),
        .i_first_delay   (r_delay),
        .i_interval      (r_interval),
        .o_result        (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.valid) begin
            r_code    <= w_result.pulse_code;
            r_second  <= w_result.second_index;
            r_synced  <= w_result.frame_synced;
            r_min_end <= w_result.minute_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_code   = r_code;
    assign o_second_index = r_second;
    assign o_frame_synced = r_synced;
    assign o_minute_end   = r_min_end;

`ifndef SYNTH
    // A result never names a second outside the minute.
    a_second_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_second_index <= SEC_LAST))
        else $error("second index out of range");

    // The minute-end flag marks exactly the last second.
    a_minute_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_minute_end == (o_second_index == SEC_LAST)))
        else $error("minute end flag disagrees with second index");

    // A held input item is not lost while the output side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_op)))
        else $error("stalled input item dropped");
`endif

endmodule

[src/tcps_sampler.sv]
// ----------------------------------------------------------------------------
// tcps_sampler
// Sampler state and the per-item update: second counter, tick timer, sample
// shift register, marker run and frame sync. Produces the classified second.
// ----------------------------------------------------------------------------
module tcps_sampler #(
    parameter int TIMER_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_operation,
    input  logic                      i_carrier_level,
    input  logic [tcps_pkg::CFG_W-1:0] i_first_delay,
    input  logic [tcps_pkg::CFG_W-1:0] i_interval,
    output tcps_pkg::t_result         o_result
);
    import tcps_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [PHASE_W-1:0]    r_phase,   n_phase;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic [3:0]            r_bits,    n_bits;
    logic [SEC_W-1:0]      r_second,  n_second;
    logic [1:0]            r_run,     n_run;
    logic                  r_sync,    n_sync;

    logic [TIMER_BITS-1:0] w_inc;
    logic [CFG_W-1:0]      w_limit;
    logic                  w_hit;
    logic [3:0]            w_shifted;
    logic [1:0]            w_code;

    // Saturating tick count and the threshold of the current phase.
    assign w_inc     = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign w_limit   = (r_phase == PH_WAIT) ? i_first_delay : i_interval;
    assign w_hit     = CMP_W'(w_inc) >= CMP_W'(w_limit);
    assign w_shifted = {r_bits[2:0], i_carrier_level};
    assign w_code    = classify(w_shifted);

    // Next state and result for one item.
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_bits    = r_bits;
        n_second  = r_second;
        n_run     = r_run;
        n_sync    = r_sync;
        o_result  = '0;

        if (i_operation == OP_PULSE) begin
            n_second = (r_second == SEC_LAST) ? '0 : r_second + 1'b1;
            n_phase  = PH_ARMED;
        end else begin
            case (r_phase)
                PH_ARMED: begin
                    n_elapsed = '0;
                    n_bits    = '0;
                    n_phase   = PH_WAIT;
                end
                PH_WAIT, PH_READ0, PH_READ1, PH_READ2: begin
                    if (!w_hit) begin
                        n_elapsed = w_inc;
                    end else begin
                        n_elapsed = '0;
                        n_bits    = w_shifted;
                        if (r_phase != PH_READ2) begin
                            n_phase = r_phase + 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                            if (w_code == CODE_MARKER) begin
                                n_run = (r_run == RUN_MAX) ? r_run : r_run + 1'b1;
                            end else begin
                                n_run = '0;
                            end
                            if (n_run == RUN_SYNC) begin
                                n_second = '0;
                                n_sync   = 1'b1;
                            end
                            o_result.valid        = 1'b1;
                            o_result.pulse_code   = w_code;
                            o_result.second_index = n_second;
                            o_result.frame_synced = n_sync;
                            o_result.minute_end   = (n_second == SEC_LAST);
                        end
                    end
                end
                default: begin
                    // Idle, done and the unused code ignore ticks.
                end
            endcase
        end
        if (!i_step) begin
            o_result.valid = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_bits    <= '0;
            r_second  <= '0;
            r_run     <= '0;
            r_sync    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_bits    <= n_bits;
            r_second  <= n_second;
            r_run     <= n_run;
            r_sync    <= n_sync;
        end
    end

endmodule

[bench/time_code_pulse_sampler_top_tb.sv]
// ----------------------------------------------------------------------------
// time_code_pulse_sampler_top_tb
// Drives ticks and second pulses into the time code pulse sampler and checks
// every classified second against a cycle-free model of the sampler that
// runs alongside it. Named tests cover the register defaults, each pulse code
// and the double-marker sync, the register extremes, the minute rollover,
// a long output stall and random sequences under several settings.
// ----------------------------------------------------------------------------
module time_code_pulse_sampler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcps_pkg::*;

    localparam int TIMER_BITS     = 20;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 240;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // Pulse code for each 4-bit sample pattern, first sample in the MSB.
    localparam logic [1:0] PATTERN_CODE [16] = '{
        CODE_MARKER, CODE_UNDEF, CODE_UNDEF, CODE_UNDEF,
        CODE_HIGH,   CODE_UNDEF, CODE_UNDEF, CODE_LOW,
        CODE_HIGH,   CODE_LOW,   CODE_HIGH,  CODE_LOW,
        CODE_HIGH,   CODE_LOW,   CODE_HIGH,  CODE_LOW
    };

    typedef struct {
        logic [1:0]       code;
        logic [SEC_W-1:0] second;
        logic             synced;
        logic             minute_end;
    } t_code_result;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    // Block ports.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic                 i_operation     = OP_TICK;
    logic                 i_carrier_level = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [1:0]           o_pulse_code;
    logic [SEC_W-1:0]     o_second_index;
    logic                 o_frame_synced;
    logic                 o_minute_end;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = REG_FIRST_DELAY;
    logic [CFG_W-1:0]     i_cfg_data      = '0;

    // Sampler model state and its copy of the registers.
    logic [CFG_W-1:0]      cfg_first;
    logic [CFG_W-1:0]      cfg_interval;
    logic [PHASE_W-1:0]    m_phase;
    logic [TIMER_BITS-1:0] m_elapsed;
    logic [3:0]            m_bits;
    logic [SEC_W-1:0]      m_second;
    logic [1:0]            m_run;
    logic                  m_sync;

    t_code_result pending_codes[$];
    int           codes_predicted = 0;
    int           items_sent      = 0;
    int           mismatches      = 0;
    int           burst_left      = 0;
    bit           gaps_on         = 1'b1;
    bit           hold_request    = 1'b0;

    time_code_pulse_sampler_top #(
        .TIMER_BITS(TIMER_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_carrier_level(i_carrier_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pulse_code   (o_pulse_code),
        .o_second_index (o_second_index),
        .o_frame_synced (o_frame_synced),
        .o_minute_end   (o_minute_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Model state after reset.
    function automatic void reset_sampler_model();
        cfg_first    = FIRST_DELAY_RST;
        cfg_interval = INTERVAL_RST;
        m_phase      = PH_IDLE;
        m_elapsed    = '0;
        m_bits       = '0;
        m_second     = '0;
        m_run        = '0;
        m_sync       = 1'b0;
    endfunction

    // Advances the model by one accepted item and queues the classified
    // second when the fourth sample completes a pattern.
    function automatic void advance_sampler(input logic op, input logic lvl);
        logic [CFG_W-1:0] limit;
        logic [1:0]       code;
        t_code_result     res;
        if (op == OP_PULSE) begin
            m_second = (m_second == SEC_LAST) ? '0 : m_second + 1'b1;
            m_phase  = PH_ARMED;
            return;
        end
        case (m_phase)
            PH_ARMED: begin
                m_elapsed = '0;
                m_bits    = '0;
                m_phase   = PH_WAIT;
                return;
            end
            PH_WAIT, PH_READ0, PH_READ1, PH_READ2: ;
            default: return;
        endcase
        if (m_elapsed != TIMER_MAX)
            m_elapsed = m_elapsed + 1'b1;
        limit = (m_phase == PH_WAIT) ? cfg_first : cfg_interval;
        if (m_elapsed < limit)
            return;
        m_bits    = {m_bits[2:0], lvl};
        m_elapsed = '0;
        if (m_phase != PH_READ2) begin
            m_phase = m_phase + 1'b1;
            return;
        end
        m_phase = PH_DONE;
        code    = PATTERN_CODE[m_bits];
        if (code == CODE_MARKER) begin
            if (m_run != RUN_MAX)
                m_run = m_run + 1'b1;
        end else begin
            m_run = '0;
        end
        if (m_run == RUN_SYNC) begin
            m_second = '0;
            m_sync   = 1'b1;
        end
        res.code       = code;
        res.second     = m_second;
        res.synced     = m_sync;
        res.minute_end = (m_second == SEC_LAST);
        pending_codes.push_back(res);
        codes_predicted++;
    endfunction

    // Sends one item, with a random gap at the start of each burst.
    task automatic send_event(input logic op, input logic lvl);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_carrier_level <= lvl;
        do @(posedge i_clk); while (!o_in_ready);
        advance_sampler(op, lvl);
        items_sent++;
    endtask

    // Writes one register; the channel idles afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FIRST_DELAY)
            cfg_first = data;
        else if (idx == REG_INTERVAL)
            cfg_interval = data;
        @(posedge i_clk);
    endtask

    // Waits until every predicted second has come out and the pipeline is
    // empty of items that cause no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] interval);
        settle();
        write_reg(REG_FIRST_DELAY, first);
        write_reg(REG_INTERVAL, interval);
    endtask

    // One well-formed second: pulse, the clearing tick, then filler ticks
    // with the pattern bits placed on the four sampling ticks.
    task automatic send_second(input logic [3:0] pattern);
        int limit;
        send_event(OP_PULSE, 1'($urandom_range(0, 1)));
        send_event(OP_TICK, 1'($urandom_range(0, 1)));
        for (int s = 3; s >= 0; s--) begin
            limit = (s == 3) ? int'(cfg_first) : int'(cfg_interval);
            if (limit == 0)
                limit = 1;
            repeat (limit - 1) send_event(OP_TICK, 1'($urandom_range(0, 1)));
            send_event(OP_TICK, pattern[s]);
        end
    endtask

    // A second cut short; the next pulse restarts the sampler.
    task automatic send_broken_second();
        send_event(OP_PULSE, 1'($urandom_range(0, 1)));
        send_event(OP_TICK, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) send_event(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Reset values: ticks while idle are ignored, and the interval keeps
    // its default while only the first delay is shortened.
    task automatic test_reset_defaults();
        repeat (3) send_event(OP_TICK, 1'($urandom_range(0, 1)));
        settle();
        write_reg(REG_FIRST_DELAY, 20'd2);
        send_second(4'b1000);
    endtask

    // Every pulse code, the double marker and a pulse during sampling, with
    // zero delays so each sample lands on the first tick of its phase.
    task automatic test_pulse_codes();
        set_timing('0, '0);
        repeat (2) send_event(OP_TICK, 1'($urandom_range(0, 1)));
        repeat (3) send_second(4'b0000);
        send_second(4'b1000);
        send_broken_second();
        send_second(4'b0111);
        send_second(4'b0001);
    endtask

    // Largest delays are not reached by the ticks sent here; writes to unused indexes change nothing.
    task automatic test_register_extremes();
        set_timing('1, '1);
        send_broken_second();
        repeat (4) send_event(OP_TICK, 1'($urandom_range(0, 1)));
        set_timing(20'd1, 20'd1);
        write_reg(4'hF, 20'h5A5A5);
        write_reg(4'd2, '0);
        send_second(4'b1111);
    endtask

    // Sync on a double marker, then count through a whole minute, mostly
    // with bare pulses, so the last second flags the minute end.
    task automatic test_minute_rollover();
        set_timing(20'd2, 20'd1);
        repeat (2) send_second(4'b0000);
        for (int k = 1; k <= 60; k++) begin
            if (k % 12 == 0 || k >= 58)
                send_second(4'($urandom_range(1, 15)));
            else
                send_event(OP_PULSE, 1'($urandom_range(0, 1)));
        end
    endtask

    // The receiver holds off for a long stretch while seconds stream in
    // back to back, so the block fills and stalls its input.
    task automatic test_output_stall();
        set_timing('0, '0);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (15) send_second(4'($urandom_range(0, 15)));
        gaps_on = 1'b1;
    endtask

    // Random mix: mostly complete seconds with random patterns, markers
    // weighted up so double markers occur, plus broken seconds and noise.
    task automatic run_random_mix(input int n_items, input int min_codes);
        int start_items;
        int start_codes;
        int pick;
        start_items = items_sent;
        start_codes = codes_predicted;
        while (items_sent - start_items < n_items || codes_predicted - start_codes < min_codes) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_second(($urandom_range(0, 3) == 0) ? 4'b0000 : 4'($urandom_range(0, 15)));
            else if (pick < 82)
                send_broken_second();
            else if (pick < 90)
                send_event(OP_PULSE, 1'($urandom_range(0, 1)));
            else
                repeat ($urandom_range(1, 4)) send_event(OP_TICK, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_sequences();
        int base_codes;
        base_codes = codes_predicted;
        set_timing(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 2)));
        run_random_mix(110, 0);
        set_timing(20'd1, 20'd1);
        gaps_on = 1'b0;
        run_random_mix(110, 0);
        gaps_on = 1'b1;
        set_timing(CFG_W'($urandom_range(10, 30)), CFG_W'($urandom_range(4, 10)));
        run_random_mix(110, 0);
        set_timing(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 2)));
        run_random_mix(110, 48 - (codes_predicted - base_codes));
    endtask

    // Receiver stalls: segments of random modes, plus one long hold-off
    // when a test asks for it.
    initial begin : drive_out_ready
        int       seg_left;
        int       hold_left;
        t_rx_mode mode;
        seg_left  = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 120);
                end
                seg_left--;
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 5) == 0);
                    default:   i_out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Compare each result item with the oldest predicted second.
    always @(posedge i_clk) begin : check_results
        t_code_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_codes.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected item: code %0d second %0d synced %0b end %0b",
                             o_pulse_code, o_second_index, o_frame_synced, o_minute_end);
                mismatches++;
            end else begin
                want = pending_codes.pop_front();
                if (o_pulse_code !== want.code || o_second_index !== want.second ||
                    o_frame_synced !== want.synced || o_minute_end !== want.minute_end) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("mismatch: expected code %0d second %0d synced %0b end %0b, %s",
                                 want.code, want.second, want.synced, want.minute_end,
                                 $sformatf("got code %0d second %0d synced %0b end %0b",
                                           o_pulse_code, o_second_index, o_frame_synced,
                                           o_minute_end));
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        reset_sampler_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_pulse_codes();
        test_register_extremes();
        test_minute_rollover();
        test_output_stall();
        test_random_sequences();

        settle();
        repeat (10) @(posedge i_clk);
        if (pending_codes.size() != 0) begin
            $display("%0d predicted seconds never came out", pending_codes.size());
            mismatches += pending_codes.size();
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
